### hw/rtl/two_byte_delimited_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms for the deframer port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_BYTE_DELIMITED_DEFRAMER_CORE_MACROS_SVH
`define TWO_BYTE_DELIMITED_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication.
`define TBDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication.
`define TBDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### hw/rtl/tbdd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Widths, register indexes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbdd_pkg;

    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 7;
    localparam int CFG_IDX_W         = 3;
    localparam int DEF_MAX_FRAME_LEN = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 3'd5;

    localparam logic [LEN_W-1:0] RST_MIN_LEN = 7'd0;
    localparam logic [LEN_W-1:0] RST_MAX_LEN = 7'd65;

    typedef struct packed {
        logic accept;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_go;
        logic out_last;
    } t_dp_sts;

endpackage

### hw/rtl/tbdd_if.sv
// ----------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for received bytes, frame bytes and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tbdd_rx_if;
    logic                       valid;
    logic                       ready;
    logic [tbdd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tbdd_frame_if;
    logic                       valid;
    logic                       ready;
    logic [tbdd_pkg::BYTE_W-1:0] frame_byte;
    logic                       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface tbdd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tbdd_pkg::CFG_IDX_W-1:0] index;
    logic [tbdd_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/two_byte_delimited_deframer_core.sv
// ----------------------------------------------------------------------------
// Two-byte delimited deframer core
// Hunts for a two-byte head, stores bytes up to a two-byte tail and emits
// frames whose length passes the min/max check.
//
//   channel   direction  payload                 accepted when
//   i_rx      in         rx_byte                 valid && ready
//   o_frame   out        frame_byte, frame_last  valid && ready
//   i_cfg     in         index, data             valid && ready (always ready)
//
// Received words are taken while the controller is idle; each frame word is
// read through the frame store read port in a load state, then a send state held until ready.
// Intake stalls while a frame is read out; o_frame stalls hold the word.
// Reset is synchronous; the frame store needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_byte_delimited_deframer_core #(
    parameter int MAX_FRAME_LEN = tbdd_pkg::DEF_MAX_FRAME_LEN
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tbdd_rx_if.sink      i_rx,
    tbdd_frame_if.source o_frame,
    tbdd_cfg_if.sink     i_cfg
);
    import tbdd_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign i_cfg.ready = 1'b1;

    tbdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .o_in_ready  (i_rx.ready),
        .o_out_valid (o_frame.valid),
        .i_out_ready (o_frame.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tbdd_datapath #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_rx_byte    (i_rx.rx_byte),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_frame_byte (o_frame.frame_byte),
        .o_frame_last (o_frame.frame_last)
    );

endmodule

### hw/rtl/tbdd_ctrl.sv
// ----------------------------------------------------------------------------
// Deframer controller
// Sequences byte intake and frame readout one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tbdd_pkg::t_dp_sts i_sts,
    output tbdd_pkg::t_dp_cmd o_cmd
);
    import tbdd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.emit_go) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready) begin
                    n_state = i_sts.out_last ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_SEND);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.load   = (r_state == S_LOAD);

endmodule

### hw/rtl/tbdd_datapath.sv
// ----------------------------------------------------------------------------
// Deframer datapath
// Marker match, frame store, length check and output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbdd_datapath #(
    parameter int MAX_FRAME_LEN = tbdd_pkg::DEF_MAX_FRAME_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbdd_pkg::t_dp_cmd             i_cmd,
    output tbdd_pkg::t_dp_sts             o_sts,
    input  logic [tbdd_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                          i_cfg_we,
    input  logic [tbdd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbdd_pkg::BYTE_W-1:0]    i_cfg_data,
    output logic [tbdd_pkg::BYTE_W-1:0]    o_frame_byte,
    output logic                          o_frame_last
);
    import tbdd_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_LEN);
    localparam int CW = $clog2(MAX_FRAME_LEN + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    logic [BYTE_W-1:0] r_mem [MAX_FRAME_LEN];
    logic [BYTE_W-1:0] r_rd_data;

    logic [BYTE_W-1:0] r_head_first;
    logic [BYTE_W-1:0] r_head_second;
    logic [BYTE_W-1:0] r_tail_first;
    logic [BYTE_W-1:0] r_tail_second;
    logic [LEN_W-1:0]  r_min_len;
    logic [LEN_W-1:0]  r_max_len;

    logic              r_in_frame;
    logic              n_in_frame;
    logic [BYTE_W-1:0] r_prev_byte;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [BYTE_W-1:0] r_first;
    logic [CW-1:0]     r_emit_len;
    logic [AW-1:0]     r_rd_idx;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              w_head;
    logic              w_tail;
    logic              w_ovf;
    logic              w_store;
    logic [CW-1:0]     w_len;
    logic [AW-1:0]     w_wr_addr;
    logic              w_len_ok;
    logic              w_emit;

    assign w_head    = !r_in_frame && (r_prev_byte == r_head_first)
                       && (i_rx_byte == r_head_second);
    assign w_tail    = (r_prev_byte == r_tail_first) && (i_rx_byte == r_tail_second);
    assign w_ovf     = r_in_frame && (r_count >= CW'(MAX_FRAME_LEN));
    assign w_store   = w_head || (r_in_frame && !w_ovf);
    assign w_len     = w_head ? CW'(2) : (r_count + CW'(1));
    assign w_wr_addr = w_head ? AW'(1) : r_count[AW-1:0];
    assign w_len_ok  = (LW'(w_len) > LW'(r_min_len)) && (LW'(w_len) < LW'(r_max_len));
    assign w_emit    = w_store && w_tail && w_len_ok;

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        if (i_cmd.accept) begin
            if (w_store) begin
                n_in_frame = !w_tail;
                n_count    = w_tail ? '0 : w_len;
            end else if (w_ovf) begin
                n_in_frame = 1'b0;
                n_count    = '0;
            end
        end
    end

    // Frame store: one write on intake, one registered read for readout.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_store) begin
            r_mem[w_wr_addr] <= i_rx_byte;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_head) begin
            r_first <= r_prev_byte;
        end
        if (i_cmd.accept && w_emit) begin
            r_emit_len <= w_len;
        end
        if (i_cmd.load) begin
            r_out_byte <= (r_rd_idx == '0) ? r_first : r_rd_data;
            r_out_last <= ((CW'(r_rd_idx) + CW'(1)) == r_emit_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first  <= '0;
            r_head_second <= '0;
            r_tail_first  <= '0;
            r_tail_second <= '0;
            r_min_len     <= RST_MIN_LEN;
            r_max_len     <= RST_MAX_LEN;
            r_in_frame    <= 1'b0;
            r_prev_byte   <= '0;
            r_count       <= '0;
            r_rd_idx      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HEAD_FIRST:  r_head_first  <= i_cfg_data;
                    CFG_HEAD_SECOND: r_head_second <= i_cfg_data;
                    CFG_TAIL_FIRST:  r_tail_first  <= i_cfg_data;
                    CFG_TAIL_SECOND: r_tail_second <= i_cfg_data;
                    CFG_MIN_LEN:     r_min_len     <= i_cfg_data[LEN_W-1:0];
                    CFG_MAX_LEN:     r_max_len     <= i_cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            if (i_cmd.accept) begin
                r_prev_byte <= i_rx_byte;
                r_rd_idx    <= '0;
            end else if (i_cmd.load) begin
                r_rd_idx <= r_rd_idx + AW'(1);
            end
        end
    end

    assign o_sts.emit_go  = w_emit;
    assign o_sts.out_last = r_out_last;
    assign o_frame_byte   = r_out_byte;
    assign o_frame_last   = r_out_last;

endmodule

### hw/rtl/tbdd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Port-level properties of intake, readout and frame termination.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "two_byte_delimited_deframer_core_macros.svh"

module tbdd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tbdd_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_out_last
);
    import tbdd_pkg::*;

    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    `TBDD_ASSERT_NOW(a_no_intake_in_readout, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    `TBDD_ASSERT_NEXT(a_no_word_after_intake, i_clk, i_rst_n, w_in_acc, !i_out_valid)
    `TBDD_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, w_out_acc && i_out_last, !i_out_valid && i_in_ready)
    `TBDD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last))

endmodule

bind two_byte_delimited_deframer_core tbdd_checker u_tbdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rx.valid),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_out_byte  (o_frame.frame_byte),
    .i_out_last  (o_frame.frame_last)
);

### tb/tb_two_byte_delimited_deframer_core.sv
// ----------------------------------------------------------------------------
// Two-byte delimited deframer testbench
// Drives received words with random gaps and register writes between phases,
// stalls the frame channel at random, and checks every frame word against a
// local deframer predictor (head hunt, tail detect, length window, overflow).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_byte_delimited_deframer_core;

    import tbdd_pkg::*;

    localparam int FRAME_CAP   = DEF_MAX_FRAME_LEN;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        ITEM_RX,
        ITEM_CFG,
        ITEM_DRAIN
    } t_item_kind;

    typedef struct {
        t_item_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    data;
        int                   gap;
    } t_word_item;

    typedef struct packed {
        logic [BYTE_W-1:0] fbyte;
        logic              last;
    } t_frame_word;

    logic i_clk;
    logic i_rst_n;

    tbdd_rx_if    rx_if ();
    tbdd_frame_if frame_if ();
    tbdd_cfg_if   cfg_if ();

    two_byte_delimited_deframer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if),
        .i_cfg   (cfg_if)
    );

    t_word_item  rx_pending_q[$];
    t_frame_word frame_expect_q[$];

    // predictor copy of registers and state
    logic [BYTE_W-1:0] mark_h0   = '0;
    logic [BYTE_W-1:0] mark_h1   = '0;
    logic [BYTE_W-1:0] mark_t0   = '0;
    logic [BYTE_W-1:0] mark_t1   = '0;
    int                len_floor = int'(RST_MIN_LEN);
    int                len_ceil  = int'(RST_MAX_LEN);
    logic              framing   = 1'b0;
    logic [BYTE_W-1:0] last_byte = '0;
    logic [BYTE_W-1:0] frame_buf [FRAME_CAP];
    int                frame_cnt = 0;

    // stimulus generation state
    logic [BYTE_W-1:0] gen_h0;
    logic [BYTE_W-1:0] gen_h1;
    logic [BYTE_W-1:0] gen_t0;
    logic [BYTE_W-1:0] gen_t1;
    logic [BYTE_W-1:0] last_queued = '0;
    bit                gaps_on     = 1'b1;
    int                frame_words = 0;

    int err_cnt      = 0;
    int rx_words     = 0;
    int cfg_writes   = 0;
    int words_seen   = 0;
    int frames_seen  = 0;
    int cycle_cnt    = 0;
    int gap_cnt      = 0;
    int settle_cnt   = 0;
    int stall_cnt    = 0;
    int mode_cnt     = 0;
    bit stall_mode   = 1'b0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rx_gap();
        if ($urandom_range(99) < 55) return 0;
        return idle_len();
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        $display("[%0t] frame word %0d %s: got %0h, expected %0h",
                 $time, words_seen, what, got, want);
        err_cnt++;
    endtask

    function automatic void reg_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [BYTE_W-1:0] data);
        case (idx)
            CFG_HEAD_FIRST:  mark_h0 = data;
            CFG_HEAD_SECOND: mark_h1 = data;
            CFG_TAIL_FIRST:  mark_t0 = data;
            CFG_TAIL_SECOND: mark_t1 = data;
            CFG_MIN_LEN:     len_floor = int'(data[LEN_W-1:0]);
            CFG_MAX_LEN:     len_ceil = int'(data[LEN_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic void close_on_tail(input logic [BYTE_W-1:0] cur);
        t_frame_word w;
        int          k;
        if (last_byte == mark_t0 && cur == mark_t1) begin
            if (frame_cnt > len_floor && frame_cnt < len_ceil) begin
                for (k = 0; k < frame_cnt; k++) begin
                    w.fbyte = frame_buf[k];
                    w.last  = (k + 1 == frame_cnt);
                    frame_expect_q.push_back(w);
                end
            end
            framing   = 1'b0;
            frame_cnt = 0;
        end
    endfunction

    function automatic void deframe_predict(input logic [BYTE_W-1:0] cur);
        if (!framing) begin
            if (last_byte == mark_h0 && cur == mark_h1) begin
                frame_buf[0] = last_byte;
                frame_buf[1] = cur;
                frame_cnt    = 2;
                framing      = 1'b1;
                close_on_tail(cur);
            end
        end else if (frame_cnt >= FRAME_CAP) begin
            framing   = 1'b0;
            frame_cnt = 0;
        end else begin
            frame_buf[frame_cnt] = cur;
            frame_cnt++;
            close_on_tail(cur);
        end
        last_byte = cur;
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] data);
        t_word_item it;
        it.kind = ITEM_RX;
        it.idx  = '0;
        it.data = data;
        it.gap  = gaps_on ? rx_gap() : 0;
        rx_pending_q.push_back(it);
        last_queued = data;
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        t_word_item it;
        it.kind = ITEM_CFG;
        it.idx  = idx;
        it.data = data;
        it.gap  = 0;
        rx_pending_q.push_back(it);
    endtask

    task automatic push_drain();
        t_word_item it;
        it.kind = ITEM_DRAIN;
        it.idx  = '0;
        it.data = '0;
        it.gap  = 0;
        rx_pending_q.push_back(it);
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] h1,
                               input logic [BYTE_W-1:0] t0, input logic [BYTE_W-1:0] t1,
                               input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
        push_drain();
        push_cfg(CFG_HEAD_FIRST, h0);
        push_cfg(CFG_HEAD_SECOND, h1);
        push_cfg(CFG_TAIL_FIRST, t0);
        push_cfg(CFG_TAIL_SECOND, t1);
        push_cfg(CFG_MIN_LEN, lo);
        push_cfg(CFG_MAX_LEN, hi);
        push_cfg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom));
        gen_h0 = h0;
        gen_h1 = h1;
        gen_t0 = t0;
        gen_t1 = t1;
    endtask

    // at random, reuse the previous word as head when it already matches
    task automatic push_frame(input int body_len, input bit broken);
        int k;
        int cut;
        if (!(last_queued == gen_h0 && $urandom_range(1) == 1)) begin
            push_byte(gen_h0);
            frame_words++;
        end
        push_byte(gen_h1);
        cut = broken ? int'($urandom_range(body_len)) : body_len;
        for (k = 0; k < cut; k++) push_byte(8'($urandom));
        frame_words += cut + 1;
        if (!broken) begin
            push_byte(gen_t0);
            push_byte(gen_t1);
            frame_words += 2;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : stim_proc
        int ph;
        int budget;
        int k;
        logic [BYTE_W-1:0] h0, h1, t0, t1, lo, hi;

        i_rst_n           = 1'b0;
        rx_if.valid       = 1'b0;
        rx_if.rx_byte     = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        frame_if.ready    = 1'b0;

        // reset markers: all-zero head and tail overlap into two-word frames
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);

        set_markers(8'h7E, 8'h81, 8'h0D, 8'h0A, 8'd4, 8'd10);
        push_byte(8'h7E); push_byte(8'h81); push_byte(8'h0D); push_byte(8'h0A);
        push_byte(8'h7E); push_byte(8'h81); push_byte(8'hFF);
        push_byte(8'h0D); push_byte(8'h0A);
        push_byte(8'h7E); push_byte(8'h81);
        for (k = 1; k <= 6; k++) push_byte(k[BYTE_W-1:0]);
        push_byte(8'h0D); push_byte(8'h0A);

        for (ph = 0; ph < 5; ph++) begin
            h0 = 8'($urandom);
            h1 = 8'($urandom);
            t0 = 8'($urandom);
            t1 = 8'($urandom);
            lo = {1'($urandom_range(1)), 7'($urandom_range(0, 6))};
            hi = {1'($urandom_range(1)), 7'd65};
            budget = 6;
            gaps_on = (ph != 0);
            case (ph)
                1: begin
                    t1 = h0;
                    hi = {1'($urandom_range(1)), 7'd127};
                    budget = 64;
                end
                2: begin
                    t0 = h0;
                    t1 = h1;
                    lo = {1'($urandom_range(1)), 7'($urandom_range(0, 1))};
                    hi = {1'($urandom_range(1)), 7'($urandom_range(3, 20))};
                    budget = 10;
                end
                3: begin
                    lo = 8'hFF;
                    hi = {1'($urandom_range(1)), 7'd0};
                    budget = 4;
                end
                4: budget = 64;
                default: ;
            endcase
            set_markers(h0, h1, t0, t1, lo, hi);
            frame_words = 0;
            if (ph == 1) begin
                push_frame(60, 1'b0);
                push_drain();
            end
            if (ph == 4) push_frame(61, 1'b0);
            while (frame_words < budget) begin
                if ($urandom_range(99) < 30) begin
                    for (k = $urandom_range(1, 3); k > 0; k--) push_byte(8'($urandom));
                end
                if ($urandom_range(99) < 80) push_frame(int'($urandom_range(0, 10)), 1'b0);
                else push_frame(int'($urandom_range(0, 10)), 1'b1);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending_q.size() != 0 || rx_if.valid || cfg_if.valid) @(posedge i_clk);
        while (frame_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d received words and %0d register writes over the reset markers",
                 rx_words, cfg_writes);
        $display("and six programmed marker sets; checked %0d frame words in %0d frames",
                 words_seen, frames_seen);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin : drive_proc
        logic       rx_v;
        logic       cfg_v;
        t_word_item it;
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
            cfg_if.valid  <= 1'b0;
            cfg_if.index  <= '0;
            cfg_if.data   <= '0;
            gap_cnt       <= 0;
            settle_cnt    <= 0;
        end else begin
            rx_v  = rx_if.valid && !rx_if.ready;
            cfg_v = cfg_if.valid && !cfg_if.ready;
            if (gap_cnt != 0) begin
                gap_cnt <= gap_cnt - 1;
            end else if (!rx_v && !cfg_v && rx_pending_q.size() != 0) begin
                it = rx_pending_q[0];
                case (it.kind)
                    ITEM_RX: begin
                        void'(rx_pending_q.pop_front());
                        rx_v = 1'b1;
                        rx_if.rx_byte <= it.data;
                        gap_cnt <= it.gap;
                    end
                    ITEM_CFG: begin
                        void'(rx_pending_q.pop_front());
                        cfg_v = 1'b1;
                        cfg_if.index <= it.idx;
                        cfg_if.data  <= it.data;
                    end
                    default: begin
                        if (frame_expect_q.size() == 0 && !rx_if.valid) begin
                            if (settle_cnt >= SETTLE) begin
                                void'(rx_pending_q.pop_front());
                                settle_cnt <= 0;
                            end else begin
                                settle_cnt <= settle_cnt + 1;
                            end
                        end else begin
                            settle_cnt <= 0;
                        end
                    end
                endcase
            end
            rx_if.valid  <= rx_v;
            cfg_if.valid <= cfg_v;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
            stall_cnt      <= 0;
            mode_cnt       <= 0;
            stall_mode     <= 1'b0;
        end else begin
            if (mode_cnt == 0) begin
                stall_mode <= ($urandom_range(2) != 0);
                mode_cnt   <= $urandom_range(100, 400);
            end else begin
                mode_cnt <= mode_cnt - 1;
            end
            if (stall_cnt != 0) begin
                frame_if.ready <= 1'b0;
                stall_cnt      <= stall_cnt - 1;
            end else if (stall_mode && $urandom_range(3) == 0) begin
                frame_if.ready <= 1'b0;
                stall_cnt      <= idle_len() - 1;
            end else begin
                frame_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_frame_word want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                reg_write(cfg_if.index, cfg_if.data);
                cfg_writes++;
            end
            if (rx_if.valid && rx_if.ready) begin
                deframe_predict(rx_if.rx_byte);
                rx_words++;
            end
            if (frame_if.valid && frame_if.ready) begin
                if (frame_expect_q.size() == 0) begin
                    report_mismatch("unexpected word", frame_if.frame_byte, '0);
                end else begin
                    want = frame_expect_q.pop_front();
                    if (frame_if.frame_byte !== want.fbyte)
                        report_mismatch("frame_byte", frame_if.frame_byte, want.fbyte);
                    if (frame_if.frame_last !== want.last)
                        report_mismatch("frame_last", 8'(frame_if.frame_last), 8'(want.last));
                end
                words_seen++;
                if (frame_if.frame_last === 1'b1) frames_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d frame words outstanding",
                     cycle_cnt, frame_expect_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tbdd_pkg.sv
hw/rtl/tbdd_if.sv
hw/rtl/tbdd_ctrl.sv
hw/rtl/tbdd_datapath.sv
hw/rtl/two_byte_delimited_deframer_core.sv
hw/rtl/tbdd_checker.sv
tb/tb_two_byte_delimited_deframer_core.sv
